### hdl/lkvc_pkg.sv
package lkvc_pkg;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic             MODE_PUT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic update;
    logic respond;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

### hdl/lru_key_value_cache.sv
// fully associative key-value cache with least-recently-used replacement. a request is a get
// (mode 0) or a put (mode 1) and always yields one result: hit, the stored value on a get hit,
// and whether a put evicted the least recent entry or was dropped at capacity zero. the key is
// compared against all entries in the cycle it is accepted, ranks and the value memory port
// are updated in the next, and the registered memory read returns in the response state, when the
// result is loaded into the output register. the response state repeats while that register
// still holds a result the sink has not taken. a new request is accepted while the previous
// result still waits there. capacity writes are taken at any time and reset to 16; values
// above ENTRIES act as ENTRIES. lowering it drops nothing until a later put miss.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // mode[0], lookup_key[32:1], write_value[64:33], zero pad
  input  logic [lkvc_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // hit[0], read_value[32:1], evicted[33], zero pad
  output logic [lkvc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  // capacity[4:0], upper bits ignored
  input  logic [lkvc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned FW = lkvc_pkg::FIELD_W;

  lkvc_pkg::cmd_t cmd;
  lkvc_pkg::sts_t sts;

  logic                 hit;
  logic signed [FW-1:0] read_value;
  logic                 evicted;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lkvc_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (s_axis_tdata_i[0]),
    .lookup_key_i   (s_axis_tdata_i[FW:1]),
    .write_value_i  (s_axis_tdata_i[2*FW:FW+1]),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_capacity_i (cfg_data_i[lkvc_pkg::CAP_W-1:0]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .hit_o          (hit),
    .read_value_o   (read_value),
    .evicted_o      (evicted)
  );

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = {{(lkvc_pkg::OUT_TDATA_W - FW - 2){1'b0}}, evicted, read_value, hit};

endmodule

### hdl/lkvc_ram.sv
module lkvc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                      wr_data_i,
  input  logic                                  rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                      rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/lkvc_ctrl.sv
module lkvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lkvc_pkg::sts_t    sts_i,
  output lkvc_pkg::cmd_t    cmd_o
);

  lkvc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lkvc_pkg::ST_UPDATE;
        end
      end
      lkvc_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = lkvc_pkg::ST_RESP;
      end
      lkvc_pkg::ST_RESP: begin
        // wait until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.respond = 1'b1;
          state_d       = lkvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/lkvc_datapath.sv
module lkvc_datapath #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lkvc_pkg::cmd_t                    cmd_i,
  output lkvc_pkg::sts_t                    sts_o,
  input  logic                              mode_i,
  input  logic signed [lkvc_pkg::FIELD_W-1:0] lookup_key_i,
  input  logic signed [lkvc_pkg::FIELD_W-1:0] write_value_i,
  input  logic                              cfg_valid_i,
  input  logic [lkvc_pkg::CAP_W-1:0]        cfg_capacity_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic signed [lkvc_pkg::FIELD_W-1:0] read_value_o,
  output logic                              evicted_o
);

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned OCC_W  = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;
  localparam int unsigned FW     = lkvc_pkg::FIELD_W;

  // per-entry state
  logic [ENTRIES-1:0]    valid_q;
  logic [KEY_BITS-1:0]   key_q  [ENTRIES];
  logic [RANK_W-1:0]     rank_q [ENTRIES];
  logic [OCC_W-1:0]      occ_q;
  logic [lkvc_pkg::CAP_W-1:0] cap_q;

  // captured request and lookup outcome
  logic                  put_q;
  logic [KEY_BITS-1:0]   req_key_q;
  logic [VALUE_BITS-1:0] req_value_q;
  logic                  hit_q;
  logic [ENTRIES-1:0]    match_q;
  logic [IDX_W-1:0]      found_idx_q;
  logic                  evict_q;
  logic                  store_q;
  logic                  drop_q;
  logic [ENTRIES-1:0]    victim_q;

  // output register
  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [FW-1:0]         out_value_q;
  logic                  out_evicted_q;

  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] value_in;
  logic [ENTRIES-1:0]    match_d;
  logic                  hit_d;
  logic [IDX_W-1:0]      found_idx_d;
  logic [ENTRIES-1:0]    victim_d;
  logic [RANK_W-1:0]     occ_m1;
  logic                  put_in;
  logic                  cap_zero;
  logic                  at_cap;
  logic                  miss_put;

  logic [ENTRIES-1:0]    free_vec;
  logic [ENTRIES-1:0]    keep_vec;
  logic [IDX_W-1:0]      slot_idx;
  logic [RANK_W-1:0]     hit_rank;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic                  ram_rd_en;
  logic [VALUE_BITS-1:0] ram_rd_data;
  logic [FW-1:0]         rd_ext;

  // field narrowing and sign extension to the configured widths
  if (KEY_BITS <= FW) begin : g_key_narrow
    assign key_in = lookup_key_i[KEY_BITS-1:0];
  end else begin : g_key_wide
    assign key_in = {{(KEY_BITS - FW){lookup_key_i[FW-1]}}, lookup_key_i};
  end

  if (VALUE_BITS <= FW) begin : g_val_narrow
    assign value_in = write_value_i[VALUE_BITS-1:0];
  end else begin : g_val_wide
    assign value_in = {{(VALUE_BITS - FW){write_value_i[FW-1]}}, write_value_i};
  end

  if (VALUE_BITS >= FW) begin : g_rd_wide
    assign rd_ext = ram_rd_data[FW-1:0];
  end else begin : g_rd_narrow
    assign rd_ext = {{(FW - VALUE_BITS){ram_rd_data[VALUE_BITS-1]}}, ram_rd_data};
  end

  // key compare across all entries and eviction decision
  assign occ_m1   = RANK_W'(occ_q - OCC_W'(1));
  assign put_in   = (mode_i == lkvc_pkg::MODE_PUT);
  assign cap_zero = (cap_q == '0);
  assign at_cap   = (occ_q == OCC_W'(ENTRIES)) || (CMP_W'(occ_q) >= CMP_W'(cap_q));
  assign miss_put = put_in && !hit_d;

  always_comb begin
    found_idx_d = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i]  = valid_q[i] && (key_q[i] == key_in);
      victim_d[i] = valid_q[i] && (rank_q[i] == occ_m1);
      if (match_d[i]) begin
        found_idx_d = found_idx_d | IDX_W'(i);
      end
    end
  end

  assign hit_d = |match_d;

  // free slot after a possible eviction, lowest index first
  assign keep_vec = valid_q & ~(evict_q ? victim_q : '0);
  assign free_vec = ~keep_vec;

  always_comb begin
    slot_idx = '0;
    hit_rank = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        slot_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_rank = hit_rank | rank_q[i];
      end
    end
  end

  assign ram_wr_en   = cmd_i.update && put_q && (hit_q || store_q);
  assign ram_wr_addr = hit_q ? found_idx_q : slot_idx;
  assign ram_rd_en   = cmd_i.update && !put_q && hit_q;

  lkvc_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (req_value_q),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (found_idx_q),
    .rd_data_o (ram_rd_data)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      put_q       <= put_in;
      req_key_q   <= key_in;
      req_value_q <= value_in;
      hit_q       <= hit_d;
      match_q     <= match_d;
      found_idx_q <= found_idx_d;
      victim_q    <= victim_d;
      evict_q     <= miss_put && !cap_zero && at_cap;
      store_q     <= miss_put && !cap_zero;
      drop_q      <= miss_put && cap_zero;
    end
    if (cmd_i.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (hit_q) begin
          // move the touched entry to the front
          if (match_q[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end else if (store_q) begin
          if (slot_idx == IDX_W'(i)) begin
            rank_q[i] <= '0;
            key_q[i]  <= req_key_q;
          end else if (keep_vec[i]) begin
            rank_q[i] <= rank_q[i] + RANK_W'(1);
          end
        end
      end
    end
    if (cmd_i.respond) begin
      out_hit_q     <= hit_q;
      out_value_q   <= (hit_q && !put_q) ? rd_ext : '0;
      out_evicted_q <= evict_q || drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      cap_q       <= lkvc_pkg::CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_capacity_i;
      end
      if (cmd_i.update && store_q) begin
        valid_q <= keep_vec | (ENTRIES'(1) << slot_idx);
        if (!evict_q) begin
          occ_q <= occ_q + OCC_W'(1);
        end
      end
      if (cmd_i.respond) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign read_value_o   = out_value_q;
  assign evicted_o      = out_evicted_q;

endmodule
